[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every sampled edge out of reset.
`define PSDF_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Same-cycle implication.
`define PSDF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define PSDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/psdf_pkg.sv]
`default_nettype none

package psdf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 12;
  localparam int LABEL_W   = 12;
  localparam int COORD_W   = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;
  localparam logic [CFG_W-1:0]     DIM_RESET = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_NONE = 12'd0;
  localparam logic [LABEL_W-1:0] LABEL_PEAK = 12'd1;
  localparam logic [LABEL_W-1:0] LABEL_MAX  = 12'd4095;

  // neighbor offset codes: -1, 0, +1
  localparam logic [1:0] OFS_MINUS = 2'd0;
  localparam logic [1:0] OFS_ZERO  = 2'd1;
  localparam logic [1:0] OFS_PLUS  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [SAMPLE_W-1:0] sample;
    logic               last_sample;
    logic [INDEX_W-1:0] voxel_index;
  } item_t;

  typedef struct packed {
    logic [LABEL_W-1:0]  ring_label;
    logic [COORD_W-1:0]  peak_x;
    logic [COORD_W-1:0]  peak_y;
    logic [COORD_W-1:0]  peak_z;
    logic [SAMPLE_W-1:0] intensity_range;
    logic [LABEL_W-1:0]  ring_count;
    logic                flood_done;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_SEED,
    ST_POP,
    ST_FETCH,
    ST_CVAL,
    ST_NCALC,
    ST_NREAD,
    ST_NTEST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic read_emit;
    logic clear;
    logic scan;
    logic seed;
    logic pop;
    logic next_ring;
    logic fetch;
    logic latch_v;
    logic ncalc;
    logic nread;
    logic ntest;
    logic off_adv;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic res_busy;
    logic cnt_last;
    logic ring_empty;
    logic no_new;
    logic nb_ok;
    logic off_last;
  } stat_t;

endpackage

`default_nettype wire

[rtl/psdf_stream_if.sv]
`default_nettype none

interface psdf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/psdf_ram.sv]
`default_nettype none

module psdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

[rtl/psdf_ctrl.sv]
`default_nettype none

module psdf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            item_op,
  input  logic            item_last,
  output logic            item_ready,
  input  psdf_pkg::stat_t stat,
  output psdf_pkg::cmd_t  cmd
);
  import psdf_pkg::*;

  state_t state, state_next;
  logic   take;

  assign take = (state == ST_IDLE) && !stat.res_busy && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (stat.cnt_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          if (item_op == OP_READ) begin
            state_next = ST_READ;
          end else if (item_last) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_READ:   state_next = ST_IDLE;
      ST_SCAN:   if (stat.cnt_last) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_SEED;
      ST_SEED:   state_next = ST_POP;
      ST_POP: begin
        if (!stat.ring_empty) begin
          state_next = ST_FETCH;
        end else if (stat.no_new) begin
          state_next = ST_FINISH;
        end
      end
      ST_FETCH:  state_next = ST_CVAL;
      ST_CVAL:   state_next = ST_NCALC;
      ST_NCALC:  state_next = ST_NREAD;
      ST_NREAD: begin
        if (stat.nb_ok) begin
          state_next = ST_NTEST;
        end else begin
          state_next = stat.off_last ? ST_POP : ST_NCALC;
        end
      end
      ST_NTEST:  state_next = stat.off_last ? ST_POP : ST_NCALC;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        item_ready = !stat.res_busy;
        cmd.accept = take;
      end
      ST_READ:  cmd.read_emit = 1'b1;
      ST_SCAN: begin
        cmd.clear = 1'b1;
        cmd.scan  = 1'b1;
      end
      ST_DRAIN: ;
      ST_SEED:  cmd.seed = 1'b1;
      ST_POP: begin
        cmd.pop       = !stat.ring_empty;
        cmd.next_ring = stat.ring_empty && !stat.no_new;
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_CVAL:  cmd.latch_v = 1'b1;
      ST_NCALC: cmd.ncalc = 1'b1;
      ST_NREAD: begin
        cmd.nread   = stat.nb_ok;
        cmd.off_adv = !stat.nb_ok;
      end
      ST_NTEST: begin
        cmd.ntest   = 1'b1;
        cmd.off_adv = 1'b1;
      end
      ST_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end
endmodule

`default_nettype wire

[rtl/psdf_dp.sv]
`default_nettype none
`include "assert_macros.svh"

module psdf_dp #(
  parameter int DIM_MAX     = 16,
  parameter int VOXELS      = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  psdf_pkg::cmd_t                  cmd,
  output psdf_pkg::stat_t                 stat,
  input  psdf_pkg::item_t                 item,
  output logic                            res_valid,
  output psdf_pkg::result_t               res,
  input  logic                            res_ready,
  input  logic                            cfg_we,
  input  logic [psdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psdf_pkg::CFG_W-1:0]      cfg_data
);
  import psdf_pkg::*;

  localparam int AW = $clog2(VOXELS);
  localparam int CW = $clog2(DIM_MAX);
  localparam int DW = $clog2(DIM_MAX + 1);
  localparam int PW = 3 * DW;
  localparam int SB = SAMPLE_BITS;
  localparam int QW = AW + 3 * CW;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = DW'(1);
    end else if (32'(d) > DIM_MAX) begin
      r = DW'(DIM_MAX);
    end else begin
      r = DW'(d);
    end
    return r;
  endfunction

  // dimensions, kept clamped
  logic [DW-1:0]   dx, dy, dz;
  logic [2*DW-1:0] nxy;
  logic [PW-1:0]   nvox;

  always_ff @(posedge clk) begin
    if (rst) begin
      dx <= clamp_dim(DIM_RESET);
      dy <= clamp_dim(DIM_RESET);
      dz <= clamp_dim(DIM_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_X: dx <= clamp_dim(cfg_data);
        REG_DIM_Y: dy <= clamp_dim(cfg_data);
        REG_DIM_Z: dz <= clamp_dim(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    nxy <= (2*DW)'(dx) * (2*DW)'(dy);
  end
  assign nvox = PW'(nxy) * PW'(dz);

  // memories
  logic          s_we, l_we, q_we;
  logic [AW-1:0] s_waddr, s_raddr, l_waddr, l_raddr, q_waddr, q_raddr;
  logic [SB-1:0] s_wdata, s_rdata;
  logic [LABEL_W-1:0] l_wdata, l_rdata;
  logic [QW-1:0] q_wdata, q_rdata;

  psdf_ram #(.WIDTH(SB), .DEPTH(VOXELS)) u_samples (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  psdf_ram #(.WIDTH(LABEL_W), .DEPTH(VOXELS)) u_labels (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );
  psdf_ram #(.WIDTH(QW), .DEPTH(VOXELS)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  // registers
  logic [AW-1:0]      pos, cnt;
  logic [CW-1:0]      sx, sy, sz;
  logic               tg_vld, tg_first;
  logic [AW-1:0]      tg_idx;
  logic [CW-1:0]      tg_x, tg_y, tg_z;
  logic [SB-1:0]      hi, lo, range_r;
  logic [AW-1:0]      pk_idx;
  logic [CW-1:0]      pk_x, pk_y, pk_z;
  logic [AW:0]        qw, qr, ring_end;
  logic [LABEL_W-1:0] ring, ring_count, next_label;
  logic               done;
  logic [CW-1:0]      cur_x, cur_y, cur_z;
  logic [SB-1:0]      cur_v;
  logic [1:0]         ox, oy, oz;
  logic               nb_ok;
  logic [AW-1:0]      ni_r;
  logic [CW-1:0]      nb_x, nb_y, nb_z;
  logic               vi_ok;

  logic               is_load, load_short, in_n, hit;
  logic [CW:0]        bxp, byp, bzp;
  logic [CW-1:0]      bx, by, bz;
  logic [PW-1:0]      ni_full;
  logic               b_in, center;
  logic signed [SB:0]   diff;
  logic signed [SB+8:0] scaled;
  logic [AW-1:0]      q_idx;

  assign is_load    = cmd.accept && (item.operation == OP_LOAD);
  assign load_short = is_load && !item.last_sample;
  assign in_n       = 32'(cnt) < 32'(nvox);
  assign next_label = (ring != LABEL_MAX) ? ring + LABEL_PEAK : ring;
  assign q_idx      = q_rdata[QW-1 -: AW];

  // neighbor coordinates, offset by one so that -1 shows as zero
  assign bxp    = (CW+1)'(cur_x) + (CW+1)'(ox);
  assign byp    = (CW+1)'(cur_y) + (CW+1)'(oy);
  assign bzp    = (CW+1)'(cur_z) + (CW+1)'(oz);
  assign bx     = CW'(bxp - (CW+1)'(1));
  assign by     = CW'(byp - (CW+1)'(1));
  assign bz     = CW'(bzp - (CW+1)'(1));
  assign center = (ox == OFS_ZERO) && (oy == OFS_ZERO) && (oz == OFS_ZERO);
  assign b_in   = (bxp != '0) && (byp != '0) && (bzp != '0) &&
                  (bxp <= (CW+1)'(dx)) && (byp <= (CW+1)'(dy)) && (bzp <= (CW+1)'(dz));
  assign ni_full = PW'(bz) * PW'(nxy) + PW'(by) * PW'(dx) + PW'(bx);

  // 100 * (parent - neighbor) + range > 0
  assign diff   = $signed({1'b0, cur_v}) - $signed({1'b0, s_rdata});
  assign scaled = (diff <<< 6) + (diff <<< 5) + (diff <<< 2) + $signed({9'b0, range_r});
  assign hit    = (l_rdata == LABEL_NONE) && !scaled[SB+8] && (scaled != '0);

  always_comb begin
    s_we    = is_load;
    s_waddr = pos;
    s_wdata = SB'(item.sample);
    priority if (cmd.scan) begin
      s_raddr = cnt;
    end else if (cmd.fetch) begin
      s_raddr = q_idx;
    end else begin
      s_raddr = ni_r;
    end

    l_we = cmd.clear || cmd.seed || (cmd.ntest && hit);
    priority if (cmd.clear) begin
      l_waddr = cnt;
      l_wdata = LABEL_NONE;
    end else if (cmd.seed) begin
      l_waddr = pk_idx;
      l_wdata = LABEL_PEAK;
    end else begin
      l_waddr = ni_r;
      l_wdata = next_label;
    end
    l_raddr = cmd.accept ? AW'(item.voxel_index) : ni_r;

    q_we = cmd.seed || (cmd.ntest && hit);
    if (cmd.seed) begin
      q_waddr = '0;
      q_wdata = {pk_idx, pk_z, pk_y, pk_x};
    end else begin
      q_waddr = qw[AW-1:0];
      q_wdata = {ni_r, nb_z, nb_y, nb_x};
    end
    q_raddr = qr[AW-1:0];
  end

  // scan counter and raster coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      tg_vld <= 1'b0;
    end else begin
      if (cmd.clear) begin
        cnt <= (cnt == AW'(VOXELS - 1)) ? '0 : cnt + AW'(1);
      end
      tg_vld <= cmd.scan && in_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sx <= '0;
      sy <= '0;
      sz <= '0;
    end else if (cmd.scan) begin
      if ((CW+1)'(sx) + (CW+1)'(1) == (CW+1)'(dx)) begin
        sx <= '0;
        if ((CW+1)'(sy) + (CW+1)'(1) == (CW+1)'(dy)) begin
          sy <= '0;
          sz <= sz + CW'(1);
        end else begin
          sy <= sy + CW'(1);
        end
      end else begin
        sx <= sx + CW'(1);
      end
    end
    tg_first <= (cnt == '0);
    tg_idx   <= cnt;
    tg_x     <= sx;
    tg_y     <= sy;
    tg_z     <= sz;
    if (rst) begin
      pk_x <= '0;
      pk_y <= '0;
      pk_z <= '0;
    end else if (tg_vld) begin
      if (tg_first || s_rdata > hi) begin
        hi     <= s_rdata;
        pk_idx <= tg_idx;
        pk_x   <= tg_x;
        pk_y   <= tg_y;
        pk_z   <= tg_z;
      end
      if (tg_first || s_rdata < lo) begin
        lo <= s_rdata;
      end
    end
  end

  // flood bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      qw         <= '0;
      qr         <= '0;
      ring_end   <= '0;
      ring       <= LABEL_NONE;
      ring_count <= LABEL_NONE;
      done       <= 1'b0;
      range_r    <= '0;
      res_valid  <= 1'b0;
      res        <= '0;
    end else begin
      if (is_load) begin
        if (item.last_sample) begin
          pos <= '0;
        end else begin
          pos  <= (pos == AW'(VOXELS - 1)) ? '0 : pos + AW'(1);
          done <= 1'b0;
        end
      end
      if (cmd.seed) begin
        range_r  <= hi - lo;
        qw       <= (AW+1)'(1);
        qr       <= '0;
        ring_end <= (AW+1)'(1);
        ring     <= LABEL_PEAK;
      end
      if (cmd.pop) begin
        qr <= qr + (AW+1)'(1);
      end
      if (cmd.next_ring) begin
        ring     <= next_label;
        ring_end <= qw;
      end
      if (cmd.ntest && hit) begin
        qw <= qw + (AW+1)'(1);
      end
      if (cmd.finish) begin
        ring_count <= ring;
        done       <= 1'b1;
      end

      if (load_short || cmd.read_emit || cmd.finish) begin
        res_valid           <= 1'b1;
        res.ring_label      <= (cmd.read_emit && vi_ok) ? l_rdata : LABEL_NONE;
        res.peak_x          <= COORD_W'(pk_x);
        res.peak_y          <= COORD_W'(pk_y);
        res.peak_z          <= COORD_W'(pk_z);
        res.intensity_range <= SAMPLE_W'(range_r);
        res.ring_count      <= cmd.finish ? ring : ring_count;
        res.flood_done      <= cmd.finish ? 1'b1 : (load_short ? 1'b0 : done);
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // current voxel and neighbor walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      vi_ok <= 32'(item.voxel_index) < VOXELS;
    end
    if (cmd.fetch) begin
      cur_x <= q_rdata[CW-1:0];
      cur_y <= q_rdata[2*CW-1 -: CW];
      cur_z <= q_rdata[3*CW-1 -: CW];
    end
    if (cmd.latch_v) begin
      cur_v <= s_rdata;
      ox    <= OFS_MINUS;
      oy    <= OFS_MINUS;
      oz    <= OFS_MINUS;
    end else if (cmd.off_adv) begin
      if (oz == OFS_PLUS) begin
        oz <= OFS_MINUS;
        if (oy == OFS_PLUS) begin
          oy <= OFS_MINUS;
          ox <= ox + 2'd1;
        end else begin
          oy <= oy + 2'd1;
        end
      end else begin
        oz <= oz + 2'd1;
      end
    end
    if (cmd.ncalc) begin
      nb_ok <= b_in && !center && (32'(ni_full) < VOXELS);
      ni_r  <= AW'(ni_full);
      nb_x  <= bx;
      nb_y  <= by;
      nb_z  <= bz;
    end
  end

  always_comb begin
    stat.res_busy   = res_valid && !res_ready;
    stat.cnt_last   = cnt == AW'(VOXELS - 1);
    stat.ring_empty = qr == ring_end;
    stat.no_new     = qw == ring_end;
    stat.nb_ok      = nb_ok;
    stat.off_last   = (ox == OFS_PLUS) && (oy == OFS_PLUS) && (oz == OFS_PLUS);
  end

  `PSDF_ASSERT_ALWAYS(a_queue_order, clk, rst, (qr <= ring_end) && (ring_end <= qw))
  `PSDF_ASSERT_ALWAYS(a_queue_bound, clk, rst, 32'(qw) <= VOXELS)
  `PSDF_ASSERT_NEXT(a_finish_result, clk, rst, cmd.finish, res_valid && res.flood_done)
  `PSDF_ASSERT_NEXT(a_load_result, clk, rst, load_short, res_valid && !res.flood_done)
endmodule

`default_nettype wire

[rtl/peak_seeded_downhill_flood_unit.sv]
`default_nettype none
// Peak-seeded downhill flood over a 3D volume.
// item channel: operation 0 loads one sample (raster order, x fastest);
//   last_sample on a load starts the flood. operation 1 reads the ring label
//   of voxel_index. result channel: one transfer per item, carrying the label
//   (0 for loads), peak coordinates, intensity range, ring count and done flag.
// Sequence: a plain load gives its result the cycle after the transfer, a read
//   after the label memory read and result registers. A last sample runs label
//   clearing and max/min scan of all VOXELS addresses through the sample memory
//   port, a drain and a seed step, then per flooded voxel a pop, fetch and value
//   step, for each of its 26 neighbors an address, a read and, if valid, a test
//   step, one ring step per ring and a finish step, paced by single read ports.
// Throughput: one item at a time; a new item is taken once the result of the
//   previous one is produced and the result register is free or draining.
// Reset: a clearing pass over all VOXELS addresses zeroes the label memory; no
//   item is taken until it ends. Configuration writes are taken at any time.
// A stalled receiver holds the result; the next item waits until it is taken.

module peak_seeded_downhill_flood_unit #(
  parameter int DIM_MAX     = 16,
  parameter int VOXELS      = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  psdf_stream_if.sink                    item,
  psdf_stream_if.source                  result,
  input  logic                           cfg_we,
  input  logic [psdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psdf_pkg::CFG_W-1:0]     cfg_data
);
  import psdf_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  logic    item_ready;
  logic    res_valid;
  result_t res;
  item_t   item_data;

  assign item_data = item.payload;

  psdf_ctrl u_ctrl (
    .clk,
    .rst,
    .item_valid (item.valid),
    .item_op    (item_data.operation),
    .item_last  (item_data.last_sample),
    .item_ready,
    .stat,
    .cmd
  );

  psdf_dp #(
    .DIM_MAX     (DIM_MAX),
    .VOXELS      (VOXELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk,
    .rst,
    .cmd,
    .stat,
    .item      (item_data),
    .res_valid,
    .res,
    .res_ready (result.ready),
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  assign item.ready     = item_ready;
  assign result.valid   = res_valid;
  assign result.payload = res;
endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import psdf_pkg::*;

  localparam int VOX        = 4096;
  localparam int CYCLE_CAP  = 4000000;
  localparam int TAIL_WAIT  = 64;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  psdf_stream_if #(.payload_t(item_t))   item_ch ();
  psdf_stream_if #(.payload_t(result_t)) result_ch ();

  peak_seeded_downhill_flood_unit dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted block state
  logic [4:0]          dim_reg [3];
  logic [SAMPLE_W-1:0] sample_mem [VOX];
  logic [LABEL_W-1:0]  ring_mem [VOX];
  int                  load_pos;
  logic [COORD_W-1:0]  peak_x_m, peak_y_m, peak_z_m;
  logic [SAMPLE_W-1:0] range_m;
  logic [LABEL_W-1:0]  ring_cnt_m;
  logic                done_m;

  result_t pending_results[$];
  int      mismatches;
  int      items_sent;
  int      cycles;
  bit      idle_en;
  bit      hold_req;
  int      hold_len;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int eff_dim(input logic [4:0] d);
    if (d == 0) return 1;
    if (d > 16) return 16;
    return int'(d);
  endfunction

  function automatic void flood_model();
    int nx, ny, nz, n, hi, lo, pk, ring, next_label, c, cx, cy, cz, v, bx, by, bz, ni;
    int cur[$];
    int nxt[$];
    nx = eff_dim(dim_reg[0]);
    ny = eff_dim(dim_reg[1]);
    nz = eff_dim(dim_reg[2]);
    n = nx * ny * nz;
    if (n > VOX) n = VOX;
    foreach (ring_mem[i]) ring_mem[i] = LABEL_NONE;
    hi = sample_mem[0];
    lo = sample_mem[0];
    pk = 0;
    for (int i = 0; i < n; i++) begin
      if (sample_mem[i] > hi) begin
        hi = sample_mem[i];
        pk = i;
      end
      if (sample_mem[i] < lo) lo = sample_mem[i];
    end
    peak_x_m = COORD_W'(pk % nx);
    peak_y_m = COORD_W'((pk / nx) % ny);
    peak_z_m = COORD_W'(pk / (nx * ny));
    range_m = SAMPLE_W'(hi - lo);
    ring_mem[pk] = LABEL_PEAK;
    cur = {cur, pk};
    ring = 1;
    while (cur.size() != 0) begin
      nxt.delete();
      next_label = (ring < LABEL_MAX) ? ring + 1 : LABEL_MAX;
      foreach (cur[f]) begin
        c = cur[f];
        cx = c % nx;
        cy = (c / nx) % ny;
        cz = c / (nx * ny);
        v = sample_mem[c];
        for (int ox = -1; ox <= 1; ox++)
          for (int oy = -1; oy <= 1; oy++)
            for (int oz = -1; oz <= 1; oz++) begin
              if (ox == 0 && oy == 0 && oz == 0) continue;
              bx = cx + ox;
              by = cy + oy;
              bz = cz + oz;
              if (bx < 0 || by < 0 || bz < 0) continue;
              if (bx >= nx || by >= ny || bz >= nz) continue;
              ni = bz * nx * ny + by * nx + bx;
              if (ni >= VOX) continue;
              if (ring_mem[ni] != LABEL_NONE) continue;
              if (100 * (v - int'(sample_mem[ni])) > -int'(range_m)) begin
                ring_mem[ni] = LABEL_W'(next_label);
                nxt = {nxt, ni};
              end
            end
      end
      if (nxt.size() != 0) ring = next_label;
      cur = nxt;
    end
    ring_cnt_m = LABEL_W'(ring);
  endfunction

  function automatic void predict_item(input item_t it);
    result_t r;
    r.ring_label = LABEL_NONE;
    if (it.operation == OP_LOAD) begin
      sample_mem[load_pos] = it.sample;
      if (it.last_sample) begin
        flood_model();
        done_m = 1'b1;
        load_pos = 0;
      end else begin
        done_m = 1'b0;
        load_pos = (load_pos + 1) % VOX;
      end
    end else begin
      r.ring_label = ring_mem[it.voxel_index];
    end
    r.peak_x = peak_x_m;
    r.peak_y = peak_y_m;
    r.peak_z = peak_z_m;
    r.intensity_range = range_m;
    r.ring_count = ring_cnt_m;
    r.flood_done = done_m;
    pending_results = {pending_results, r};
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // receiver: random stalls, long hold-off on request, check each transfer
  int stall_left;
  always @(posedge clk) begin
    result_t exp_r;
    result_t got_r;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got_r = result_ch.payload;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, got_r);
          mismatches++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("ring_label", exp_r.ring_label, got_r.ring_label);
          check_field("peak_x", exp_r.peak_x, got_r.peak_x);
          check_field("peak_y", exp_r.peak_y, got_r.peak_y);
          check_field("peak_z", exp_r.peak_z, got_r.peak_z);
          check_field("intensity_range", exp_r.intensity_range, got_r.intensity_range);
          check_field("ring_count", exp_r.ring_count, got_r.ring_count);
          check_field("flood_done", exp_r.flood_done, got_r.flood_done);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = hold_len;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input item_t it);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.payload <= it;
    do @(posedge clk); while (!item_ch.ready);
    predict_item(it);
    items_sent++;
  endtask

  task automatic send_load(input logic [SAMPLE_W-1:0] s, input logic last);
    item_t it;
    it.operation = OP_LOAD;
    it.sample = s;
    it.last_sample = last;
    it.voxel_index = INDEX_W'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input logic [INDEX_W-1:0] idx);
    item_t it;
    it.operation = OP_READ;
    it.sample = SAMPLE_W'($urandom);
    it.last_sample = 1'($urandom);
    it.voxel_index = idx;
    send_item(it);
  endtask

  // hold valid low and let every expected result arrive
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_dims(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z);
    logic [4:0] vals[3];
    vals = '{x, y, z};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i == 0) ? REG_DIM_X : (i == 1) ? REG_DIM_Y : REG_DIM_Z;
      cfg_data <= vals[i];
      @(posedge clk);
      dim_reg[i] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int volume_size();
    return eff_dim(dim_reg[0]) * eff_dim(dim_reg[1]) * eff_dim(dim_reg[2]);
  endfunction

  // load a whole volume; style 0 random, 1 smooth, 2 flat, 3 narrow
  task automatic load_volume(input int style);
    int n, base, s;
    n = volume_size();
    base = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: s = $urandom_range(0, 65535);
        1: begin
          base = base + $urandom_range(0, 600) - 300;
          if (base < 0) base = 0;
          if (base > 65535) base = 65535;
          s = base;
        end
        2: s = base;
        default: s = $urandom_range(1000, 1040);
      endcase
      send_load(SAMPLE_W'(s), i == n - 1);
    end
  endtask

  task automatic read_some(input int cnt);
    int n;
    n = volume_size();
    repeat (cnt) begin
      if ($urandom_range(0, 3) == 0) send_read(INDEX_W'($urandom));
      else send_read(INDEX_W'($urandom_range(0, n - 1)));
    end
  endtask

  task automatic test_directed();
    send_read('0);
    send_read(12'hFFF);
    drain();
    write_dims(5'd2, 5'd2, 5'd2);
    // tie at the maximum: first in raster order wins
    send_load(16'd5, 1'b0);
    send_load(16'hFFFF, 1'b0);
    send_load(16'd3, 1'b0);
    send_load(16'hFFFF, 1'b0);
    send_load(16'h0000, 1'b0);
    send_load(16'd7, 1'b0);
    send_load(16'hFFF0, 1'b0);
    send_load(16'd9, 1'b1);
    for (int i = 0; i < 8; i++) send_read(INDEX_W'(i));
    send_read(12'hFFF);
    drain();
    // zero and oversize dimensions clamp
    write_dims(5'd0, 5'd0, 5'd0);
    send_read(INDEX_W'(1));
    send_load(16'd42, 1'b1);
    send_read('0);
    drain();
    write_dims(5'd31, 5'd1, 5'd0);
    load_volume(1);
    send_read(INDEX_W'(15));
    drain();
  endtask

  task automatic test_random_volumes(input int item_goal);
    logic [4:0] d[3];
    int sel;
    while (items_sent < item_goal) begin
      drain();
      do begin
        for (int i = 0; i < 3; i++) begin
          sel = $urandom_range(0, 9);
          d[i] = (sel == 0) ? 5'd0 : (sel == 1) ? 5'($urandom_range(17, 31)) :
                 (sel == 2) ? 5'd16 : 5'($urandom_range(1, 4));
        end
      end while (eff_dim(d[0]) * eff_dim(d[1]) * eff_dim(d[2]) > 96);
      write_dims(d[0], d[1], d[2]);
      // labels from the previous flood stay visible
      if ($urandom_range(0, 2) == 0) read_some(2);
      load_volume($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3));
      read_some($urandom_range(3, 10));
    end
  endtask

  task automatic test_backpressure();
    drain();
    write_dims(5'd16, 5'd16, 5'd1);
    hold_len = 400;
    hold_req = 1'b1;
    load_volume(1);
    read_some(6);
    drain();
    // sender pauses until everything is back
    read_some(4);
    drain();
  endtask

  task automatic test_tail();
    idle_en = 1'b0;
    drain();
    write_dims(5'd3, 5'd4, 5'd2);
    load_volume(3);
    read_some(10);
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    items_sent = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    hold_len = 0;
    cfg_we = 1'b0;
    cfg_index = REG_DIM_X;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    for (int i = 0; i < 3; i++) dim_reg[i] = DIM_RESET;
    foreach (sample_mem[i]) sample_mem[i] = '0;
    foreach (ring_mem[i]) ring_mem[i] = LABEL_NONE;
    load_pos = 0;
    peak_x_m = '0;
    peak_y_m = '0;
    peak_z_m = '0;
    range_m = '0;
    ring_cnt_m = '0;
    done_m = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_volumes(560);
    test_backpressure();
    test_random_volumes(860);
    test_tail();
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
